[design/dpdc_pkg.sv]
// Shared types and fixed constants for the dual PID drive controller.
// Used by the register bank, the sequencer and the datapath.
package dpdc_pkg;

   localparam int GAIN_W         = 16;
   localparam int CSR_IDX_W      = 4;
   localparam int SUM_W          = 42;
   localparam int S_LO_W         = 21;
   localparam int POW_W          = SUM_W + GAIN_W + 1;
   localparam int MIX_W          = POW_W + 1;
   localparam int DRIVE_W        = 15;
   localparam int DRIVE_LIMIT    = 12288;
   localparam int VOLT_FRAC_BITS = 10;
   localparam int DI_W           = 9;
   localparam int TI_W           = 8;
   localparam int DI_CLAMP       = 5;
   localparam int DI_WINDOW      = 100;
   localparam int TI_CLAMP       = 100;

   localparam logic [GAIN_W-1:0] RST_DRIVE_P     = 16'd164;
   localparam logic [GAIN_W-1:0] RST_DRIVE_I     = 16'd0;
   localparam logic [GAIN_W-1:0] RST_DRIVE_D     = 16'd49;
   localparam logic [GAIN_W-1:0] RST_TURN_P      = 16'd328;
   localparam logic [GAIN_W-1:0] RST_TURN_I      = 16'd164;
   localparam logic [GAIN_W-1:0] RST_TURN_D      = 16'd33;
   localparam logic [GAIN_W-1:0] RST_DRIVE_SPEED = 16'd16384;
   localparam logic [GAIN_W-1:0] RST_TURN_SPEED  = 16'd16384;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DRIVE_P     = 4'd0,
      REG_DRIVE_I     = 4'd1,
      REG_DRIVE_D     = 4'd2,
      REG_TURN_P      = 4'd3,
      REG_TURN_I      = 4'd4,
      REG_TURN_D      = 4'd5,
      REG_DRIVE_SPEED = 4'd6,
      REG_TURN_SPEED  = 4'd7
   } reg_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] drive_p;
      logic [GAIN_W-1:0] drive_i;
      logic [GAIN_W-1:0] drive_d;
      logic [GAIN_W-1:0] turn_p;
      logic [GAIN_W-1:0] turn_i;
      logic [GAIN_W-1:0] turn_d;
      logic [GAIN_W-1:0] drive_speed;
      logic [GAIN_W-1:0] turn_speed;
   } gains_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ERR, ST_UPD,
      ST_LP, ST_LD, ST_LI, ST_LS, ST_LLO, ST_LHI, ST_LSUM,
      ST_TP, ST_TD, ST_TI, ST_TS, ST_TLO, ST_THI, ST_TSUM,
      ST_MIX, ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      MUL_NONE, MUL_E_KP, MUL_DE_KD, MUL_DI_KI, MUL_T_KP, MUL_DT_KD, MUL_TI_KI,
      MUL_SLO_D, MUL_SHI_D, MUL_SLO_T, MUL_SHI_T
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_NONE, ACC_LOAD, ACC_ADD, ACC_FINAL
   } acc_op_type;

   typedef enum logic [1:0] {
      POW_NONE, POW_LO, POW_HI_LAT, POW_HI_TRN
   } pow_op_type;

   typedef struct packed {
      logic        capture;
      logic        calc_err;
      logic        update;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      pow_op_type  pow_op;
      logic        mix;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

[design/dpdc_regs.sv]
// Gain and speed scale register bank with its write port.
// Depends on dpdc_pkg for the register index codes and reset values.
module dpdc_regs
   import dpdc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_data,
   output gains_type            gains
);

   gains_type gains_ff;
   gains_type gains_in;

   assign csr_ready = 1'b1;
   assign gains     = gains_ff;

   always_comb begin
      gains_in = gains_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DRIVE_P:     gains_in.drive_p     = csr_data;
            REG_DRIVE_I:     gains_in.drive_i     = csr_data;
            REG_DRIVE_D:     gains_in.drive_d     = csr_data;
            REG_TURN_P:      gains_in.turn_p      = csr_data;
            REG_TURN_I:      gains_in.turn_i      = csr_data;
            REG_TURN_D:      gains_in.turn_d      = csr_data;
            REG_DRIVE_SPEED: gains_in.drive_speed = csr_data;
            REG_TURN_SPEED:  gains_in.turn_speed  = csr_data;
            default:         gains_in = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.drive_p     <= RST_DRIVE_P;
         gains_ff.drive_i     <= RST_DRIVE_I;
         gains_ff.drive_d     <= RST_DRIVE_D;
         gains_ff.turn_p      <= RST_TURN_P;
         gains_ff.turn_i      <= RST_TURN_I;
         gains_ff.turn_d      <= RST_TURN_D;
         gains_ff.drive_speed <= RST_DRIVE_SPEED;
         gains_ff.turn_speed  <= RST_TURN_SPEED;
      end else begin
         gains_ff <= gains_in;
      end
   end

endmodule

[design/dpdc_ctrl.sv]
// Sequencer for one control tick: errors, lateral PID, turn PID, mix, output.
// Depends on dpdc_pkg for the state, command and status types.
module dpdc_ctrl
   import dpdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_ERR;
         end
         ST_ERR:  state_in = ST_UPD;
         ST_UPD:  state_in = ST_LP;
         ST_LP:   state_in = ST_LD;
         ST_LD:   state_in = ST_LI;
         ST_LI:   state_in = ST_LS;
         ST_LS:   state_in = ST_LLO;
         ST_LLO:  state_in = ST_LHI;
         ST_LHI:  state_in = ST_LSUM;
         ST_LSUM: state_in = ST_TP;
         ST_TP:   state_in = ST_TD;
         ST_TD:   state_in = ST_TI;
         ST_TI:   state_in = ST_TS;
         ST_TS:   state_in = ST_TLO;
         ST_TLO:  state_in = ST_THI;
         ST_THI:  state_in = ST_TSUM;
         ST_TSUM: state_in = ST_MIX;
         ST_MIX:  state_in = ST_OUT;
         ST_OUT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_ERR:  cmd.calc_err = 1'b1;
         ST_UPD:  cmd.update   = 1'b1;
         ST_LP:   cmd.mul_sel  = MUL_E_KP;
         ST_LD: begin
            cmd.mul_sel = MUL_DE_KD;
            cmd.acc_op  = ACC_LOAD;
         end
         ST_LI: begin
            cmd.mul_sel = MUL_DI_KI;
            cmd.acc_op  = ACC_ADD;
         end
         ST_LS:   cmd.acc_op  = ACC_FINAL;
         ST_LLO:  cmd.mul_sel = MUL_SLO_D;
         ST_LHI: begin
            cmd.mul_sel = MUL_SHI_D;
            cmd.pow_op  = POW_LO;
         end
         ST_LSUM: cmd.pow_op  = POW_HI_LAT;
         ST_TP:   cmd.mul_sel = MUL_T_KP;
         ST_TD: begin
            cmd.mul_sel = MUL_DT_KD;
            cmd.acc_op  = ACC_LOAD;
         end
         ST_TI: begin
            cmd.mul_sel = MUL_TI_KI;
            cmd.acc_op  = ACC_ADD;
         end
         ST_TS:   cmd.acc_op  = ACC_FINAL;
         ST_TLO:  cmd.mul_sel = MUL_SLO_T;
         ST_THI: begin
            cmd.mul_sel = MUL_SHI_T;
            cmd.pow_op  = POW_LO;
         end
         ST_TSUM: cmd.pow_op   = POW_HI_TRN;
         ST_MIX:  cmd.mix      = 1'b1;
         ST_OUT:  cmd.out_load = status.out_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/dpdc_datapath.sv]
// Datapath: error terms, integrators, shared multiplier, accumulators,
// mixing, rounding and the output register. Depends on dpdc_pkg.
module dpdc_datapath
   import dpdc_pkg::*;
#(
   parameter int POSITION_BITS  = 20,
   parameter int GAIN_FRAC_BITS = 14
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cmd_type                         cmd,
   output status_type                      status,
   input  gains_type                       gains,
   input  logic signed [POSITION_BITS-1:0] req_left_position,
   input  logic signed [POSITION_BITS-1:0] req_right_position,
   input  logic signed [POSITION_BITS-1:0] req_target_distance,
   input  logic signed [POSITION_BITS-1:0] req_target_turn,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [DRIVE_W-1:0]       rsp_left_drive,
   output logic signed [DRIVE_W-1:0]       rsp_right_drive,
   output logic                            rsp_command_saturated
);

   localparam int P   = POSITION_BITS;
   localparam int EW  = P + 1;
   localparam int DW  = P + 2;
   localparam int MA  = (DW > S_LO_W + 1) ? DW : S_LO_W + 1;
   localparam int GB  = GAIN_W + 1;
   localparam int PRW = MA + GB;
   localparam int AW  = (PRW + 2 > SUM_W + 1) ? PRW + 2 : SUM_W + 1;
   localparam int RSH = 2 * GAIN_FRAC_BITS - VOLT_FRAC_BITS;

   localparam logic signed [DW-1:0]      DiHi   = DW'(DI_CLAMP);
   localparam logic signed [DW-1:0]      DiLo   = -DiHi;
   localparam logic signed [DW-1:0]      TiHi   = DW'(TI_CLAMP);
   localparam logic signed [DW-1:0]      TiLo   = -TiHi;
   localparam logic signed [EW-1:0]      WinHi  = EW'(DI_WINDOW);
   localparam logic signed [EW-1:0]      WinLo  = -WinHi;
   localparam logic signed [EW-1:0]      EMax   = {1'b0, {(EW-1){1'b1}}};
   localparam logic signed [EW-1:0]      EMin   = {1'b1, {(EW-1){1'b0}}};
   localparam logic signed [AW-1:0]      SumMax = {{(AW-SUM_W+1){1'b0}}, 1'b1,
                                                   {(SUM_W-2){1'b0}}};
   localparam logic signed [AW-1:0]      SumMin = -SumMax;
   localparam logic signed [MIX_W-1:0]   RndHalf = MIX_W'(1) <<< (RSH - 1);
   localparam logic signed [MIX_W-1:0]   LimHi  = MIX_W'(DRIVE_LIMIT);
   localparam logic signed [MIX_W-1:0]   LimLo  = -LimHi;
   localparam logic signed [DRIVE_W-1:0] DrvHi  = DRIVE_W'(DRIVE_LIMIT);
   localparam logic signed [DRIVE_W-1:0] DrvLo  = -DrvHi;

   logic signed [P-1:0]       l_ff, r_ff, td_ff, tt_ff;
   logic signed [EW-1:0]      e_ff, t_ff, last_e_ff, last_t_ff;
   logic signed [DW-1:0]      de_ff, dt_ff;
   logic signed [DI_W-1:0]    di_ff, di_use_ff;
   logic signed [TI_W-1:0]    ti_ff;
   logic signed [PRW-1:0]     prod_ff;
   logic signed [AW-1:0]      acc_ff;
   logic signed [SUM_W-1:0]   s_ff;
   logic signed [POW_W-1:0]   pow_lo_ff, lat_ff, trn_ff;
   logic signed [MIX_W-1:0]   mix_l_ff, mix_r_ff;
   logic                      rsp_valid_ff;
   logic signed [DRIVE_W-1:0] left_ff, right_ff;
   logic                      sat_ff;

   logic signed [EW-1:0]      sum_lr, mean, diff_lr, e_in, t_in;
   logic signed [DW-1:0]      t_raw, di_sum, ti_sum;
   logic signed [DI_W-1:0]    du_in, di_in;
   logic signed [TI_W-1:0]    ti_in;
   logic signed [MA-1:0]      mul_a;
   logic signed [GB-1:0]      mul_b;
   logic signed [PRW-1:0]     prod_in;
   logic signed [AW-1:0]      acc_sum;
   logic signed [SUM_W-1:0]   s_in;
   logic signed [POW_W-1:0]   pow_in;
   logic signed [MIX_W-1:0]   ql, qr;
   logic signed [DRIVE_W-1:0] left_in, right_in;
   logic                      sat_l, sat_r;

   // error terms; mean truncates toward zero
   always_comb begin
      sum_lr  = {l_ff[P-1], l_ff} + {r_ff[P-1], r_ff};
      mean    = $signed(sum_lr + EW'(sum_lr[EW-1])) >>> 1;
      e_in    = {td_ff[P-1], td_ff} - mean;
      diff_lr = {l_ff[P-1], l_ff} - {r_ff[P-1], r_ff};
      t_raw   = {{2{tt_ff[P-1]}}, tt_ff} - {diff_lr[EW-1], diff_lr};
      if (t_raw[DW-1] != t_raw[DW-2]) begin
         t_in = t_raw[DW-1] ? EMin : EMax;
      end else begin
         t_in = t_raw[EW-1:0];
      end
   end

   // integrators
   always_comb begin
      di_sum = {{(DW-DI_W){di_ff[DI_W-1]}}, di_ff} + {e_ff[EW-1], e_ff};
      if (di_sum > DiHi) begin
         du_in = DiHi[DI_W-1:0];
      end else if (di_sum < DiLo) begin
         du_in = DiLo[DI_W-1:0];
      end else begin
         du_in = di_sum[DI_W-1:0];
      end
      if (e_ff < WinHi && e_ff > WinLo) begin
         di_in = du_in + e_ff[DI_W-1:0];
      end else begin
         di_in = '0;
      end
      ti_sum = {{(DW-TI_W){ti_ff[TI_W-1]}}, ti_ff} + {t_ff[EW-1], t_ff};
      if (ti_sum > TiHi) begin
         ti_in = TiHi[TI_W-1:0];
      end else if (ti_sum < TiLo) begin
         ti_in = TiLo[TI_W-1:0];
      end else begin
         ti_in = ti_sum[TI_W-1:0];
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_E_KP: begin
            mul_a = MA'(e_ff);
            mul_b = {1'b0, gains.drive_p};
         end
         MUL_DE_KD: begin
            mul_a = MA'(de_ff);
            mul_b = {1'b0, gains.drive_d};
         end
         MUL_DI_KI: begin
            mul_a = MA'(di_use_ff);
            mul_b = {1'b0, gains.drive_i};
         end
         MUL_T_KP: begin
            mul_a = MA'(t_ff);
            mul_b = {1'b0, gains.turn_p};
         end
         MUL_DT_KD: begin
            mul_a = MA'(dt_ff);
            mul_b = {1'b0, gains.turn_d};
         end
         MUL_TI_KI: begin
            mul_a = MA'(ti_ff);
            mul_b = {1'b0, gains.turn_i};
         end
         MUL_SLO_D: begin
            mul_a = MA'($signed({1'b0, s_ff[S_LO_W-1:0]}));
            mul_b = {1'b0, gains.drive_speed};
         end
         MUL_SHI_D: begin
            mul_a = MA'($signed(s_ff[SUM_W-1:S_LO_W]));
            mul_b = {1'b0, gains.drive_speed};
         end
         MUL_SLO_T: begin
            mul_a = MA'($signed({1'b0, s_ff[S_LO_W-1:0]}));
            mul_b = {1'b0, gains.turn_speed};
         end
         MUL_SHI_T: begin
            mul_a = MA'($signed(s_ff[SUM_W-1:S_LO_W]));
            mul_b = {1'b0, gains.turn_speed};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // PID sum clamp and speed product recombination
   always_comb begin
      acc_sum = acc_ff + AW'(prod_ff);
      if (acc_sum > SumMax) begin
         s_in = SumMax[SUM_W-1:0];
      end else if (acc_sum < SumMin) begin
         s_in = SumMin[SUM_W-1:0];
      end else begin
         s_in = acc_sum[SUM_W-1:0];
      end
      pow_in = pow_lo_ff + (POW_W'(prod_ff) <<< S_LO_W);
   end

   // rounding and saturation
   always_comb begin
      ql    = mix_l_ff >>> RSH;
      qr    = mix_r_ff >>> RSH;
      sat_l = (ql > LimHi) || (ql < LimLo);
      sat_r = (qr > LimHi) || (qr < LimLo);
      if (ql > LimHi) begin
         left_in = DrvHi;
      end else if (ql < LimLo) begin
         left_in = DrvLo;
      end else begin
         left_in = ql[DRIVE_W-1:0];
      end
      if (qr > LimHi) begin
         right_in = DrvHi;
      end else if (qr < LimLo) begin
         right_in = DrvLo;
      end else begin
         right_in = qr[DRIVE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         l_ff  <= req_left_position;
         r_ff  <= req_right_position;
         td_ff <= req_target_distance;
         tt_ff <= req_target_turn;
      end
      if (cmd.calc_err) begin
         e_ff <= e_in;
         t_ff <= t_in;
      end
      if (cmd.update) begin
         de_ff     <= {e_ff[EW-1], e_ff} - {last_e_ff[EW-1], last_e_ff};
         dt_ff     <= {t_ff[EW-1], t_ff} - {last_t_ff[EW-1], last_t_ff};
         di_use_ff <= du_in;
      end
      if (cmd.mul_sel != MUL_NONE) begin
         prod_ff <= prod_in;
      end
      case (cmd.acc_op)
         ACC_LOAD:  acc_ff <= AW'(prod_ff);
         ACC_ADD:   acc_ff <= acc_sum;
         ACC_FINAL: s_ff   <= s_in;
         default:   acc_ff <= acc_ff;
      endcase
      case (cmd.pow_op)
         POW_LO:     pow_lo_ff <= POW_W'(prod_ff);
         POW_HI_LAT: lat_ff    <= pow_in;
         POW_HI_TRN: trn_ff    <= pow_in;
         default:    pow_lo_ff <= pow_lo_ff;
      endcase
      if (cmd.mix) begin
         mix_l_ff <= MIX_W'(lat_ff) + MIX_W'(trn_ff) + RndHalf;
         mix_r_ff <= MIX_W'(lat_ff) - MIX_W'(trn_ff) + RndHalf;
      end
      if (cmd.out_load) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         sat_ff   <= sat_l || sat_r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_e_ff    <= '0;
         last_t_ff    <= '0;
         di_ff        <= '0;
         ti_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.update) begin
            last_e_ff <= e_ff;
            last_t_ff <= t_ff;
            di_ff     <= di_in;
            ti_ff     <= ti_in;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_free       = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_left_drive        = left_ff;
   assign rsp_right_drive       = right_ff;
   assign rsp_command_saturated = sat_ff;

endmodule

[design/dual_pid_drive_controller.sv]
// Dual PID differential drive controller, top level.
// The sequencer walks both PIDs through one shared multiplier, so a new input is
// taken only once the previous tick has been loaded into the output register.
// A finished result waits in the output register while the next tick runs.
// Synchronous active-high reset restores the gains and clears the errors
// and integrators; no clearing pass is needed.
module dual_pid_drive_controller
   import dpdc_pkg::*;
#(
   parameter int POSITION_BITS  = 20,
   parameter int GAIN_FRAC_BITS = 14
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [POSITION_BITS-1:0] req_left_position,
   input  logic signed [POSITION_BITS-1:0] req_right_position,
   input  logic signed [POSITION_BITS-1:0] req_target_distance,
   input  logic signed [POSITION_BITS-1:0] req_target_turn,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [DRIVE_W-1:0]       rsp_left_drive,
   output logic signed [DRIVE_W-1:0]       rsp_right_drive,
   output logic                            rsp_command_saturated,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [CSR_IDX_W-1:0]            csr_index,
   input  logic [GAIN_W-1:0]               csr_data
);

   gains_type  gains;
   cmd_type    cmd;
   status_type status;

   dpdc_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .gains     (gains)
   );

   dpdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dpdc_datapath #(
      .POSITION_BITS  (POSITION_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .gains                 (gains),
      .req_left_position     (req_left_position),
      .req_right_position    (req_right_position),
      .req_target_distance   (req_target_distance),
      .req_target_turn       (req_target_turn),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_left_drive        (rsp_left_drive),
      .rsp_right_drive       (rsp_right_drive),
      .rsp_command_saturated (rsp_command_saturated)
   );

endmodule

[design/dpdc_checker.sv]
// Port-level checks for the drive controller, bound to the top level.
// Depends on dpdc_pkg for the output width and drive limit.
module dpdc_checker
   import dpdc_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic signed [DRIVE_W-1:0] rsp_left_drive,
   input logic signed [DRIVE_W-1:0] rsp_right_drive,
   input logic                      rsp_command_saturated
);

   localparam logic signed [DRIVE_W-1:0] Lim = DRIVE_W'(DRIVE_LIMIT);

   // one tick in flight: stall follows every input transfer
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while a tick is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_drive)
         && $stable(rsp_right_drive) && $stable(rsp_command_saturated))
      else $error("stalled result changed");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_left_drive <= Lim && rsp_left_drive >= -Lim
         && rsp_right_drive <= Lim && rsp_right_drive >= -Lim)
      else $error("drive command outside limit");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command_saturated |-> rsp_left_drive == Lim
         || rsp_left_drive == -Lim || rsp_right_drive == Lim
         || rsp_right_drive == -Lim)
      else $error("saturation flagged with neither side at the limit");

endmodule

bind dual_pid_drive_controller dpdc_checker u_dpdc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_stall             (req_stall),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_left_drive        (rsp_left_drive),
   .rsp_right_drive       (rsp_right_drive),
   .rsp_command_saturated (rsp_command_saturated)
);

[bench/tb_dual_pid_drive_controller.sv]
// Testbench for dual_pid_drive_controller: directed and random control ticks,
// gain register writes, random input gaps and random output stalls, checked against a PID predictor.
// Depends on dpdc_pkg and the controller RTL.
module tb_dual_pid_drive_controller;
   timeunit 1ns;
   timeprecision 1ps;
   import dpdc_pkg::*;

   localparam int POS_W  = 20;
   localparam int FRAC_W = 14;
   localparam longint ERR_MAX  = (64'sd1 <<< POS_W) - 1;
   localparam longint ERR_MIN  = -(64'sd1 <<< POS_W);
   localparam longint SUM_CLIP = 64'sd1 <<< 40;
   localparam int VOLT_SHIFT   = 2 * FRAC_W - VOLT_FRAC_BITS;
   localparam logic [CSR_IDX_W-1:0] FIRST_UNUSED_REG = 4'd8;
   localparam logic [CSR_IDX_W-1:0] LAST_UNUSED_REG  = 4'd15;

   typedef logic signed [POS_W-1:0] position_t;

   localparam position_t POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam position_t POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   typedef struct packed {
      logic signed [DRIVE_W-1:0] left_drive;
      logic signed [DRIVE_W-1:0] right_drive;
      logic                      saturated;
   } drive_cmd_t;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   position_t                 req_left_position = '0;
   position_t                 req_right_position = '0;
   position_t                 req_target_distance = '0;
   position_t                 req_target_turn = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [DRIVE_W-1:0] rsp_left_drive;
   logic signed [DRIVE_W-1:0] rsp_right_drive;
   logic                      rsp_command_saturated;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [GAIN_W-1:0]         csr_data = '0;

   int                gain [8];
   logic [GAIN_W-1:0] gain_plan [8];
   longint            last_drive_err = 0;
   longint            drive_integ = 0;
   longint            last_turn_err = 0;
   longint            turn_integ = 0;
   drive_cmd_t        pending_commands [$];
   int                failures = 0;
   bit                calm = 1'b0;

   dual_pid_drive_controller #(
      .POSITION_BITS (POS_W),
      .GAIN_FRAC_BITS(FRAC_W)
   ) uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint pid_effort(input longint err, input longint diff,
                                         input longint integ, input int kp, input int ki,
                                         input int kd, input int speed);
      longint s;
      s = clip(err * kp + diff * kd + integ * ki, -SUM_CLIP, SUM_CLIP);
      return s * speed;
   endfunction

   function automatic logic signed [DRIVE_W-1:0] to_drive(input longint v,
                                                          inout logic clipped);
      longint r;
      r = (v + (64'sd1 <<< (VOLT_SHIFT - 1))) >>> VOLT_SHIFT;
      if (r > DRIVE_LIMIT) begin
         clipped = 1'b1;
         r = DRIVE_LIMIT;
      end else if (r < -DRIVE_LIMIT) begin
         clipped = 1'b1;
         r = -DRIVE_LIMIT;
      end
      return r[DRIVE_W-1:0];
   endfunction

   task automatic predict_drive_command(input position_t lp, input position_t rp,
                                        input position_t td, input position_t tt);
      longint l, r, e, de, t, dt, lat, trn;
      logic clipped;
      drive_cmd_t cmd;
      l = lp;
      r = rp;
      e = clip(longint'(td) - (l + r) / 2, ERR_MIN, ERR_MAX);
      de = e - last_drive_err;
      drive_integ = clip(drive_integ + e, -DI_CLAMP, DI_CLAMP);
      lat = pid_effort(e, de, drive_integ, gain[REG_DRIVE_P], gain[REG_DRIVE_I],
                       gain[REG_DRIVE_D], gain[REG_DRIVE_SPEED]);
      // integral is topped up again inside the window, cleared outside it
      if (e < DI_WINDOW && e > -DI_WINDOW) drive_integ += e;
      else drive_integ = 0;
      t = clip(longint'(tt) - (l - r), ERR_MIN, ERR_MAX);
      dt = t - last_turn_err;
      turn_integ = clip(turn_integ + t, -TI_CLAMP, TI_CLAMP);
      trn = pid_effort(t, dt, turn_integ, gain[REG_TURN_P], gain[REG_TURN_I],
                       gain[REG_TURN_D], gain[REG_TURN_SPEED]);
      clipped = 1'b0;
      cmd.left_drive = to_drive(lat + trn, clipped);
      cmd.right_drive = to_drive(lat - trn, clipped);
      cmd.saturated = clipped;
      last_drive_err = e;
      last_turn_err = t;
      pending_commands.push_back(cmd);
   endtask

   task automatic send_tick(input longint lv, input longint rv,
                            input longint tdv, input longint ttv);
      position_t lp, rp, td, tt;
      lp = POS_W'(lv);
      rp = POS_W'(rv);
      td = POS_W'(tdv);
      tt = POS_W'(ttv);
      req_valid <= 1'b1;
      req_left_position <= lp;
      req_right_position <= rp;
      req_target_distance <= td;
      req_target_turn <= tt;
      do @(posedge clock); while (req_stall);
      predict_drive_command(lp, rp, td, tt);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // wait until the controller has nothing in flight
   task automatic settle();
      if (req_valid) req_valid <= 1'b0;
      while (pending_commands.size() != 0) @(posedge clock);
   endtask

   task automatic write_gain(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] value,
                             input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (last) csr_valid <= 1'b0;
      if (idx <= REG_TURN_SPEED) gain[idx] = value;
   endtask

   task automatic program_gains();
      for (int i = REG_DRIVE_P; i <= REG_TURN_SPEED; i++)
         write_gain(CSR_IDX_W'(i), gain_plan[i], i == REG_TURN_SPEED);
   endtask

   function automatic int jitter(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic logic [GAIN_W-1:0] rand_gain();
      case ($urandom_range(0, 3))
         0: return GAIN_W'($urandom_range(0, 600));
         1: return GAIN_W'($urandom_range(0, 8191));
         2: return GAIN_W'($urandom);
         default: return $urandom_range(0, 1) ? '1 : '0;
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] rand_speed();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return GAIN_W'($urandom);
         default: return GAIN_W'($urandom_range(8192, 24576));
      endcase
   endfunction

   // mostly ticks near the targets, so the integrators see small errors
   task automatic send_random_tick();
      position_t lp, rp, td, tt;
      lp = POS_W'($urandom);
      if ($urandom_range(0, 9) < 7) begin
         rp = POS_W'(clip(longint'(lp) + jitter(150), POS_MIN, POS_MAX));
         td = POS_W'(clip((longint'(lp) + longint'(rp)) / 2 + jitter(120), POS_MIN,
                          POS_MAX));
         tt = POS_W'(clip(longint'(lp) - longint'(rp) + jitter(120), POS_MIN, POS_MAX));
      end else begin
         rp = POS_W'($urandom);
         td = POS_W'($urandom);
         tt = POS_W'($urandom);
      end
      send_tick(lp, rp, td, tt);
   endtask

   task automatic test_edge_values();
      send_tick(0, 0, 0, 0);
      send_tick(POS_MAX, POS_MAX, POS_MAX, 0);
      send_tick(POS_MIN, POS_MIN, POS_MIN, 0);
      send_tick(POS_MIN, POS_MIN, POS_MAX, POS_MAX);
      send_tick(POS_MAX, POS_MAX, POS_MIN, POS_MIN);
      // turn error beyond its range, both ways
      send_tick(POS_MIN, POS_MAX, POS_MIN, POS_MAX);
      send_tick(POS_MAX, POS_MIN, POS_MAX, POS_MIN);
      // lateral error at the edges of the integral window
      send_tick(100, 100, 199, 0);
      send_tick(100, 100, 200, 0);
      send_tick(100, 100, 1, 0);
      send_tick(100, 100, 0, 0);
      send_tick(3, -2, 0, 0);
      send_tick(-3, 0, 0, 0);
      repeat (3) send_tick(10, -10, 0, 80);
      send_tick(0, 0, -3, -1);
   endtask

   task automatic test_gain_extremes();
      settle();
      foreach (gain_plan[i]) gain_plan[i] = '1;
      program_gains();
      send_tick(5, 5, 7, 0);
      send_tick(POS_MIN, POS_MAX, POS_MAX, POS_MIN);
      settle();
      gain_plan[REG_DRIVE_SPEED] = '0;
      gain_plan[REG_TURN_SPEED] = '0;
      program_gains();
      send_tick(0, 0, POS_MAX, POS_MAX);
      settle();
      write_gain(REG_DRIVE_SPEED, '1, 1'b1);
      send_tick(0, 0, POS_MAX, POS_MAX);
      settle();
      write_gain(FIRST_UNUSED_REG, '0, 1'b0);
      write_gain(LAST_UNUSED_REG, '1, 1'b1);
      send_tick(1, 2, 30, -5);
   endtask

   task automatic test_random_ticks();
      for (int phase = 0; phase < 6; phase++) begin
         settle();
         for (int i = REG_DRIVE_P; i <= REG_TURN_D; i++) gain_plan[i] = rand_gain();
         gain_plan[REG_DRIVE_SPEED] = rand_speed();
         gain_plan[REG_TURN_SPEED] = rand_speed();
         program_gains();
         repeat (75) send_random_tick();
      end
   endtask

   task automatic test_back_to_back();
      settle();
      gain_plan = '{RST_DRIVE_P, RST_DRIVE_I, RST_DRIVE_D, RST_TURN_P,
                    RST_TURN_I, RST_TURN_D, RST_DRIVE_SPEED, RST_TURN_SPEED};
      program_gains();
      calm = 1'b1;
      repeat (50) send_random_tick();
   endtask

   initial begin
      gain_plan = '{RST_DRIVE_P, RST_DRIVE_I, RST_DRIVE_D, RST_TURN_P,
                    RST_TURN_I, RST_TURN_D, RST_DRIVE_SPEED, RST_TURN_SPEED};
      foreach (gain[i]) gain[i] = gain_plan[i];
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_values();
      test_gain_extremes();
      test_random_ticks();
      test_back_to_back();
      settle();
      repeat (40) @(posedge clock);
      if (failures == 0 && pending_commands.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      drive_cmd_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_commands.size() == 0) begin
            $error("result transfer with no command expected");
            failures++;
         end else begin
            want = pending_commands.pop_front();
            if (rsp_left_drive !== want.left_drive) begin
               $error("left_drive expected %0d got %0d", want.left_drive, rsp_left_drive);
               failures++;
            end
            if (rsp_right_drive !== want.right_drive) begin
               $error("right_drive expected %0d got %0d", want.right_drive, rsp_right_drive);
               failures++;
            end
            if (rsp_command_saturated !== want.saturated) begin
               $error("command_saturated expected %0d got %0d", want.saturated,
                      rsp_command_saturated);
               failures++;
            end
         end
      end
   end

   initial begin
      #(5_000_000);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
